// ----- rtl/core/i2csbc_pkg.sv -----
`timescale 1ns / 1ps

package i2csbc_pkg;

	localparam int RECV_DEPTH = 32;
	localparam int SEND_DEPTH = 32;

	// counters hold 0..DEPTH, indexes 0..DEPTH-1
	localparam int RCNT_W = $clog2(RECV_DEPTH + 1);
	localparam int SCNT_W = $clog2(SEND_DEPTH + 1);
	localparam int RIDX_W = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
	localparam int SIDX_W = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;

	typedef enum logic [2:0] {
		RSP_NONE      = 3'd0,
		RSP_ACK       = 3'd1,
		RSP_NACK      = 3'd2,
		RSP_DONE      = 3'd3,
		RSP_NACK_DONE = 3'd4
	} resp_t;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_ABORT   = 3'd1,
		OP_ADDR    = 3'd2,
		OP_DATA_RD = 3'd3,
		OP_DATA_WR = 3'd4,
		OP_RESET   = 3'd5
	} op_kind_t;

	typedef struct packed {
		logic       command;
		logic       bus_error;
		logic       collision;
		logic       addr_or_stop;
		logic       address_match;
		logic       read_direction;
		logic       data_flag;
		logic       master_nacked;
		logic [7:0] rx_byte;
		logic [7:0] send_count;
		logic [4:0] load_index;
		logic [7:0] load_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] response;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       reset_notice;
		logic       deliver_valid;
		logic [7:0] deliver_byte;
		logic [5:0] deliver_count;
		logic       last;
	} out_item_t;

	// classified operation passed from front to back
	typedef struct packed {
		op_kind_t          kind;
		logic              addr_match;
		logic              read_dir;
		logic              nacked;
		logic [7:0]        data;
		logic [SCNT_W-1:0] send_total;
		logic [SIDX_W-1:0] load_idx;
	} op_t;

	typedef struct packed {
		logic send_en;
		logic deliver_en;
		logic notify_en;
	} cfg_t;

endpackage

// ----- rtl/core/i2c_slave_buffer_controller_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Beat
// in        input      in_valid/in_stall  in_item  (bus event or transmit load)
// out       output     out_valid/out_stall out_item (one result, last marks end)
// cfg       input      APB psel/penable   send/deliver/notify enables
//
// A load writes the transmit buffer in the back and yields no beat; most bus
// events give their beat in the cycle after leaving the queue; a transmitted
// byte or an address/stop event passes ST_SEND or ST_FIN (buffer read or
// answer stage), and a write-frame delivery of n bytes gives one beat per cycle
// unless stalled, paced by the single read port of the receive buffer.
// Reset clears modes, counters and enables; buffer contents stay undefined until
// written. The two-deep op queue accepts until full while output is stalled.

module i2c_slave_buffer_controller_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2csbc_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2csbc_pkg::out_item_t out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_SEND_EN   = 2'd0;
	localparam logic [1:0] REG_DELIVER_EN = 2'd1;
	localparam logic [1:0] REG_NOTIFY_EN = 2'd2;

	i2csbc_pkg::cfg_t cfg_q;
	i2csbc_pkg::op_t  push_op;
	i2csbc_pkg::op_t  head;
	logic             push, pop, q_full, q_empty;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SEND_EN:    cfg_q.send_en    <= pwdata[0];
				REG_DELIVER_EN: cfg_q.deliver_en <= pwdata[0];
				REG_NOTIFY_EN:  cfg_q.notify_en  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SEND_EN:    prdata = 32'(cfg_q.send_en);
			REG_DELIVER_EN: prdata = 32'(cfg_q.deliver_en);
			REG_NOTIFY_EN:  prdata = 32'(cfg_q.notify_en);
			default:        prdata = '0;
		endcase
	end

	// front: classify and saturate, drop out-of-range loads
	i2csbc_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	i2csbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (head)
	);

	// back: transaction state, both byte buffers, output register
	i2csbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/core/i2csbc_front.sv -----
`timescale 1ns / 1ps

module i2csbc_front (
	input  logic                in_valid,
	output logic                in_stall,
	input  i2csbc_pkg::in_item_t in_item,
	input  logic                q_full,
	output logic                push,
	output i2csbc_pkg::op_t     push_op
);

	logic load_in_range;
	logic sc_over;

	assign load_in_range = 9'(in_item.load_index) < 9'(i2csbc_pkg::SEND_DEPTH);
	assign sc_over       = 9'(in_item.send_count) > 9'(i2csbc_pkg::SEND_DEPTH);

	assign in_stall = q_full;
	// out-of-range loads are dropped here and never reach the queue
	assign push = in_valid && !q_full && !(in_item.command && !load_in_range);

	always_comb begin
		push_op.addr_match = in_item.address_match;
		push_op.read_dir   = in_item.read_direction;
		push_op.nacked     = in_item.master_nacked;
		push_op.data       = in_item.command ? in_item.load_byte : in_item.rx_byte;
		push_op.send_total = sc_over ? i2csbc_pkg::SCNT_W'(i2csbc_pkg::SEND_DEPTH)
		                             : i2csbc_pkg::SCNT_W'(in_item.send_count);
		push_op.load_idx   = i2csbc_pkg::SIDX_W'(in_item.load_index);
		// flag priority: error/collision, address/stop, data, else reset
		if (in_item.command) begin
			push_op.kind = i2csbc_pkg::OP_LOAD;
		end else if (in_item.bus_error || in_item.collision) begin
			push_op.kind = i2csbc_pkg::OP_ABORT;
		end else if (in_item.addr_or_stop) begin
			push_op.kind = i2csbc_pkg::OP_ADDR;
		end else if (in_item.data_flag) begin
			push_op.kind = in_item.read_direction ? i2csbc_pkg::OP_DATA_RD
			                                      : i2csbc_pkg::OP_DATA_WR;
		end else begin
			push_op.kind = i2csbc_pkg::OP_RESET;
		end
	end

endmodule

// ----- rtl/core/i2csbc_queue.sv -----
`timescale 1ns / 1ps

module i2csbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2csbc_pkg::op_t push_op,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output i2csbc_pkg::op_t head
);

	i2csbc_pkg::op_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full  = count_q[1];
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_op;
	end

endmodule

// ----- rtl/core/i2csbc_back.sv -----
`timescale 1ns / 1ps

module i2csbc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2csbc_pkg::cfg_t      cfg,
	input  logic                  q_empty,
	input  i2csbc_pkg::op_t       head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2csbc_pkg::out_item_t out_item
);

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEND = 4'b0010,
		ST_DLV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	mode_t                         mode_q, mode_d;
	logic [i2csbc_pkg::RCNT_W-1:0] recv_cnt_q, recv_cnt_d;
	logic [i2csbc_pkg::SCNT_W-1:0] sent_cnt_q, sent_cnt_d;
	logic [i2csbc_pkg::SCNT_W-1:0] total_q, total_d;
	logic [i2csbc_pkg::RCNT_W-1:0] dlv_idx_q, dlv_idx_d;
	logic [i2csbc_pkg::RCNT_W-1:0] dlv_nxt;
	logic [i2csbc_pkg::RCNT_W-1:0] dc_q, dc_d;
	i2csbc_pkg::op_t               op_q, op_d;

	logic [7:0] send_mem [i2csbc_pkg::SEND_DEPTH];
	logic [7:0] recv_mem [i2csbc_pkg::RECV_DEPTH];
	logic [7:0] send_rd_q;
	logic [7:0] recv_rd_q;
	logic       send_wr, send_rd, recv_wr, recv_rd;
	logic [i2csbc_pkg::RIDX_W-1:0] recv_rd_addr;

	logic                  out_valid_q;
	i2csbc_pkg::out_item_t out_q;
	i2csbc_pkg::out_item_t res;
	logic                  load_out;
	logic                  out_free;
	logic                  deliver;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign dlv_nxt   = dlv_idx_q + 1'b1;
	assign deliver   = (mode_q == MODE_WRITE) && cfg.deliver_en;

	always_comb begin
		pop          = 1'b0;
		load_out     = 1'b0;
		res          = '0;
		res.last     = 1'b1;
		state_d      = state_q;
		mode_d       = mode_q;
		recv_cnt_d   = recv_cnt_q;
		sent_cnt_d   = sent_cnt_q;
		total_d      = total_q;
		dlv_idx_d    = dlv_idx_q;
		dc_d         = dc_q;
		op_d         = op_q;
		send_wr      = 1'b0;
		send_rd      = 1'b0;
		recv_wr      = 1'b0;
		recv_rd      = 1'b0;
		recv_rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (head.kind)
						i2csbc_pkg::OP_LOAD: begin
							pop     = 1'b1;
							send_wr = 1'b1;
						end
						i2csbc_pkg::OP_ADDR: begin
							// deliver first if a write frame is open, then answer
							pop  = 1'b1;
							op_d = head;
							dc_d = deliver ? recv_cnt_q : '0;
							if (deliver && recv_cnt_q != '0) begin
								dlv_idx_d = '0;
								recv_rd   = 1'b1;
								state_d   = ST_DLV;
							end else begin
								state_d = ST_FIN;
							end
						end
						i2csbc_pkg::OP_DATA_RD: begin
							if (sent_cnt_q != '0 && head.nacked) begin
								if (out_free) begin
									pop          = 1'b1;
									load_out     = 1'b1;
									mode_d       = MODE_IDLE;
									res.response = i2csbc_pkg::RSP_DONE;
								end
							end else if (sent_cnt_q < total_q &&
							             9'(sent_cnt_q) < 9'(i2csbc_pkg::SEND_DEPTH)) begin
								pop        = 1'b1;
								send_rd    = 1'b1;
								sent_cnt_d = sent_cnt_q + 1'b1;
								state_d    = ST_SEND;
							end else if (out_free) begin
								pop          = 1'b1;
								load_out     = 1'b1;
								res.response = i2csbc_pkg::RSP_DONE;
							end
						end
						i2csbc_pkg::OP_DATA_WR: begin
							if (out_free) begin
								pop      = 1'b1;
								load_out = 1'b1;
								if (7'(recv_cnt_q) < 7'(i2csbc_pkg::RECV_DEPTH)) begin
									recv_wr      = 1'b1;
									recv_cnt_d   = recv_cnt_q + 1'b1;
									res.response = i2csbc_pkg::RSP_ACK;
								end else begin
									res.response = i2csbc_pkg::RSP_NACK_DONE;
								end
							end
						end
						i2csbc_pkg::OP_ABORT: begin
							if (out_free) begin
								pop              = 1'b1;
								load_out         = 1'b1;
								mode_d           = MODE_IDLE;
								res.reset_notice = cfg.notify_en;
							end
						end
						default: begin
							// unmanaged status: full reset of the transaction
							if (out_free) begin
								pop              = 1'b1;
								load_out         = 1'b1;
								mode_d           = MODE_IDLE;
								recv_cnt_d       = '0;
								sent_cnt_d       = '0;
								res.reset_notice = cfg.notify_en;
							end
						end
					endcase
				end
			end
			ST_SEND: begin
				if (out_free) begin
					load_out     = 1'b1;
					res.response = i2csbc_pkg::RSP_ACK;
					res.tx_valid = 1'b1;
					res.tx_byte  = send_rd_q;
					state_d      = ST_IDLE;
				end
			end
			ST_DLV: begin
				if (out_free) begin
					load_out          = 1'b1;
					res.last          = 1'b0;
					res.deliver_valid = 1'b1;
					res.deliver_byte  = recv_rd_q;
					dlv_idx_d         = dlv_nxt;
					if (dlv_nxt == recv_cnt_q) begin
						state_d = ST_FIN;
					end else begin
						recv_rd      = 1'b1;
						recv_rd_addr = dlv_nxt[i2csbc_pkg::RIDX_W-1:0];
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out          = 1'b1;
					res.deliver_count = 6'(dc_q);
					state_d           = ST_IDLE;
					if (op_q.addr_match) begin
						if (op_q.read_dir) begin
							mode_d       = MODE_READ;
							res.response = i2csbc_pkg::RSP_NACK;
							if (cfg.send_en) begin
								sent_cnt_d = '0;
								total_d    = op_q.send_total;
								if (op_q.send_total != '0) res.response = i2csbc_pkg::RSP_ACK;
							end
						end else begin
							mode_d       = MODE_WRITE;
							recv_cnt_d   = '0;
							res.response = i2csbc_pkg::RSP_ACK;
						end
					end else begin
						mode_d           = MODE_IDLE;
						res.response     = i2csbc_pkg::RSP_DONE;
						res.reset_notice = cfg.notify_en;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_IDLE;
			recv_cnt_q  <= '0;
			sent_cnt_q  <= '0;
			total_q     <= '0;
			dlv_idx_q   <= '0;
			dc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			recv_cnt_q <= recv_cnt_d;
			sent_cnt_q <= sent_cnt_d;
			total_q    <= total_d;
			dlv_idx_q  <= dlv_idx_d;
			dc_q       <= dc_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		if (load_out) out_q <= res;
	end

	// buffers: one write and one registered read each
	always_ff @(posedge clk) begin
		if (send_wr) send_mem[head.load_idx] <= head.data;
		if (send_rd) send_rd_q <= send_mem[sent_cnt_q[i2csbc_pkg::SIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (recv_wr) recv_mem[recv_cnt_q[i2csbc_pkg::RIDX_W-1:0]] <= head.data;
		if (recv_rd) recv_rd_q <= recv_mem[recv_rd_addr];
	end

endmodule

// ----- bench/i2csbc_tb_pkg.sv -----
`timescale 1ns / 1ps

package i2csbc_tb_pkg;

	// control register byte addresses
	localparam logic [3:0] ADDR_SEND_EN    = 4'h0;
	localparam logic [3:0] ADDR_DELIVER_EN = 4'h4;
	localparam logic [3:0] ADDR_NOTIFY_EN  = 4'h8;

endpackage

// ----- bench/i2csbc_checker.sv -----
`timescale 1ns / 1ps

module i2csbc_checker
	import i2csbc_pkg::*;
	import i2csbc_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          pending,
	output int          errors
);

	typedef enum logic [1:0] {
		LINK_IDLE  = 2'd0,
		LINK_READ  = 2'd1,
		LINK_WRITE = 2'd2
	} link_mode_t;

	link_mode_t        mode;
	cfg_t              cfg;
	logic [RCNT_W-1:0] rx_fill;
	logic [SCNT_W-1:0] tx_sent;
	logic [SCNT_W-1:0] tx_total;
	logic [7:0]        rx_mem [RECV_DEPTH];
	logic [7:0]        tx_mem [SEND_DEPTH];
	out_item_t         want_beats [$];
	int                err_cnt;

	function automatic out_item_t closing_beat(resp_t r, logic rn);
		out_item_t o;
		o = '0;
		o.response = r;
		o.reset_notice = rn;
		o.last = 1'b1;
		return o;
	endfunction

	// one bus event: update the slave state and queue the beats it yields
	function automatic void predict_response(in_item_t b);
		out_item_t o;
		logic [5:0] dc;
		int i;
		if (b.bus_error || b.collision) begin
			mode = LINK_IDLE;
			want_beats.push_back(closing_beat(RSP_NONE, cfg.notify_en));
		end else if (b.addr_or_stop) begin
			dc = '0;
			if (mode == LINK_WRITE && cfg.deliver_en) begin
				for (i = 0; i < rx_fill; i++) begin
					o = '0;
					o.deliver_valid = 1'b1;
					o.deliver_byte = rx_mem[i];
					want_beats.push_back(o);
				end
				dc = 6'(rx_fill);
			end
			if (!b.address_match) begin
				mode = LINK_IDLE;
				o = closing_beat(RSP_DONE, cfg.notify_en);
			end else if (b.read_direction) begin
				mode = LINK_READ;
				o = closing_beat(RSP_NACK, 1'b0);
				if (cfg.send_en) begin
					tx_sent = '0;
					tx_total = (b.send_count > SEND_DEPTH) ? SCNT_W'(SEND_DEPTH)
						: SCNT_W'(b.send_count);
					if (tx_total != 0)
						o.response = RSP_ACK;
				end
			end else begin
				mode = LINK_WRITE;
				rx_fill = '0;
				o = closing_beat(RSP_ACK, 1'b0);
			end
			// frame length rides on the closing beat only
			o.deliver_count = dc;
			want_beats.push_back(o);
		end else if (b.data_flag) begin
			if (b.read_direction) begin
				if (tx_sent != 0 && b.master_nacked) begin
					mode = LINK_IDLE;
					o = closing_beat(RSP_DONE, 1'b0);
				end else if (tx_sent < tx_total && tx_sent < SEND_DEPTH) begin
					o = closing_beat(RSP_ACK, 1'b0);
					o.tx_valid = 1'b1;
					o.tx_byte = tx_mem[tx_sent];
					tx_sent++;
				end else begin
					o = closing_beat(RSP_DONE, 1'b0);
				end
			end else if (rx_fill < RECV_DEPTH) begin
				rx_mem[rx_fill] = b.rx_byte;
				rx_fill++;
				o = closing_beat(RSP_ACK, 1'b0);
			end else begin
				o = closing_beat(RSP_NACK_DONE, 1'b0);
			end
			want_beats.push_back(o);
		end else begin
			// no flag we manage: drop back to idle
			mode = LINK_IDLE;
			rx_fill = '0;
			tx_sent = '0;
			want_beats.push_back(closing_beat(RSP_NONE, cfg.notify_en));
		end
	endfunction

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] seen);
		if (seen !== want) begin
			err_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
		end
	endfunction

	function automatic void compare_beat(out_item_t got);
		out_item_t want;
		if (want_beats.size() == 0) begin
			err_cnt++;
			$display("%0t: beat expected none, got %h", $time, got);
			return;
		end
		want = want_beats.pop_front();
		check_field("response", want.response, got.response);
		check_field("tx_valid", want.tx_valid, got.tx_valid);
		check_field("tx_byte", want.tx_byte, got.tx_byte);
		check_field("reset_notice", want.reset_notice, got.reset_notice);
		check_field("deliver_valid", want.deliver_valid, got.deliver_valid);
		check_field("deliver_byte", want.deliver_byte, got.deliver_byte);
		check_field("deliver_count", want.deliver_count, got.deliver_count);
		check_field("last", want.last, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = LINK_IDLE;
			cfg = '0;
			rx_fill = '0;
			tx_sent = '0;
			tx_total = '0;
			want_beats.delete();
			err_cnt = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_SEND_EN:    cfg.send_en = pwdata[0];
					ADDR_DELIVER_EN: cfg.deliver_en = pwdata[0];
					ADDR_NOTIFY_EN:  cfg.notify_en = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				compare_beat(out_item);
			if (in_valid && !in_stall) begin
				if (in_item.command)
					tx_mem[in_item.load_index] = in_item.load_byte;
				else
					predict_response(in_item);
			end
			pending <= want_beats.size();
			errors <= err_cnt;
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	import i2csbc_pkg::*;
	import i2csbc_tb_pkg::*;

	localparam int SETTLE = 12;       // cycles to let a trailing load retire
	localparam int LIMIT  = 1500000;  // hard stop, far above the slowest run
	localparam int ITEMS  = 40;       // random beats across all phases
	localparam int PHASES = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int errors;
	int cycles = 0;
	int stall_hold = 0;
	int beats_sent = 0;
	bit calm = 1'b0;  // no gaps and no stalls while set

	// enable settings per random phase: {send, deliver, notify}
	cfg_t phase_cfg [PHASES] = '{3'b111, 3'b000, 3'b101, 3'b010, 3'b110};

	i2c_slave_buffer_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	i2csbc_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.pending(pending),
		.errors(errors)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// output backpressure: mostly short bursts, now and then a long hold
	always @(posedge clk) begin : rx_backpressure
		int r;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (calm || r < 60) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 5);
			end else if (r < 93) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Random beat of the given kind. Fields the kind does not pin down stay
	// random so every bit toggles; send_count leans small but hits 0 and 255.
	function automatic in_item_t make_beat(op_kind_t k);
		in_item_t b;
		int r;
		b.command = 1'b0;
		b.bus_error = 1'b0;
		b.collision = 1'b0;
		b.addr_or_stop = 1'b0;
		b.data_flag = 1'b0;
		b.address_match = 1'($urandom);
		b.read_direction = 1'($urandom);
		b.master_nacked = 1'($urandom);
		b.rx_byte = 8'($urandom);
		b.load_index = 5'($urandom);
		b.load_byte = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 10)
			b.send_count = 8'd0;
		else if (r < 80)
			b.send_count = 8'($urandom_range(1, 33));
		else
			b.send_count = 8'($urandom);
		case (k)
			OP_LOAD: begin
				// flags of a load are don't-care
				b.command = 1'b1;
				{b.bus_error, b.collision, b.addr_or_stop, b.data_flag} = 4'($urandom);
			end
			OP_ABORT: begin
				{b.bus_error, b.collision} = 2'($urandom_range(1, 3));
				{b.addr_or_stop, b.data_flag} = 2'($urandom);
			end
			OP_ADDR: begin
				b.addr_or_stop = 1'b1;
				b.data_flag = 1'($urandom);
			end
			OP_DATA_RD: begin
				b.data_flag = 1'b1;
				b.read_direction = 1'b1;
			end
			OP_DATA_WR: begin
				b.data_flag = 1'b1;
				b.read_direction = 1'b0;
			end
			default: ;  // OP_RESET: no flag at all
		endcase
		return b;
	endfunction

	function automatic in_item_t addr_beat(logic match, logic rd, logic [7:0] sc);
		in_item_t b;
		b = make_beat(OP_ADDR);
		b.address_match = match;
		b.read_direction = rd;
		b.send_count = sc;
		return b;
	endfunction

	function automatic in_item_t data_beat(logic rd, logic nack, logic [7:0] byte_val);
		in_item_t b;
		b = make_beat(rd ? OP_DATA_RD : OP_DATA_WR);
		b.master_nacked = nack;
		b.rx_byte = byte_val;
		return b;
	endfunction

	// Called in the time step of a rising edge; returns in the step of the
	// edge that took the beat. valid gets one NBA per step at most.
	task automatic put_beat(in_item_t b);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= b;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// hold off the sender until every predicted beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [3:0] addr, logic bit_val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {31'b0, bit_val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(cfg_t c);
		apb_write(ADDR_SEND_EN, c.send_en);
		apb_write(ADDR_DELIVER_EN, c.deliver_en);
		apb_write(ADDR_NOTIFY_EN, c.notify_en);
	endtask

	// A well-formed frame: address, len data beats, then usually a stop.
	// A stray beat is sometimes slipped in to break the sequence.
	task automatic run_frame(logic rd, int len, logic [7:0] sc);
		int i;
		int r;
		logic nack;
		put_beat(addr_beat(1'b1, rd, sc));
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 4)
				put_beat(make_beat(op_kind_t'($urandom_range(0, 5))));
			// reads end with the master's NACK most of the time
			nack = rd ? (i == len - 1 && $urandom_range(0, 9) < 7) : 1'($urandom);
			put_beat(data_beat(rd, nack, 8'($urandom)));
		end
		r = $urandom_range(0, 99);
		if (r < 70)
			put_beat(addr_beat(1'b0, 1'($urandom), 8'($urandom)));
		else if (r < 85)
			put_beat(make_beat(OP_ABORT));
		else if (r < 95)
			put_beat(make_beat(OP_RESET));
		// else: left open, the next address acts as a repeated start
	endtask

	initial begin : stimulus
		in_item_t b;
		int i;
		int ph;
		int r;
		int target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole transmit buffer first, so a read never fetches an
		// entry that was never loaded, whatever the mode.
		for (i = 0; i < SEND_DEPTH; i++) begin
			b = make_beat(OP_LOAD);
			b.load_index = 5'(i);
			b.load_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
			put_beat(b);
		end

		// --- directed, enables at reset (all off) ---
		put_beat(addr_beat(1'b1, 1'b1, 8'd5));   // read refused: sending off
		put_beat(data_beat(1'b1, 1'b0, 8'h00));  // nothing to send: complete
		put_beat(addr_beat(1'b1, 1'b0, 8'd0));   // write frame
		put_beat(data_beat(1'b0, 1'b0, 8'hFF));
		put_beat(addr_beat(1'b0, 1'b0, 8'd0));   // stop, no delivery
		b = make_beat(OP_ABORT);
		b.bus_error = 1'b1;
		b.collision = 1'b0;
		put_beat(b);
		put_beat(make_beat(OP_RESET));

		// --- directed, everything enabled ---
		drain();
		set_config(3'b111);
		put_beat(addr_beat(1'b1, 1'b0, 8'd0));
		put_beat(data_beat(1'b0, 1'b1, 8'h00));
		put_beat(data_beat(1'b0, 1'b0, 8'hFF));
		put_beat(addr_beat(1'b0, 1'b1, 8'hFF));  // stop: two bytes delivered
		put_beat(addr_beat(1'b1, 1'b1, 8'd0));   // read of zero bytes refused
		put_beat(data_beat(1'b1, 1'b1, 8'h00));  // NACK before any byte sent
		put_beat(addr_beat(1'b1, 1'b1, 8'hFF));  // offer saturates to depth
		put_beat(data_beat(1'b1, 1'b0, 8'h00));
		put_beat(data_beat(1'b1, 1'b0, 8'h00));
		put_beat(data_beat(1'b1, 1'b1, 8'h00));  // master NACK ends the read
		b = make_beat(OP_ABORT);
		b.bus_error = 1'b0;
		b.collision = 1'b1;
		put_beat(b);
		b = addr_beat(1'b1, 1'b0, 8'd0);         // address wins over data
		b.data_flag = 1'b1;
		put_beat(b);
		b = make_beat(OP_ABORT);                 // error wins over everything
		{b.bus_error, b.collision, b.addr_or_stop, b.data_flag} = 4'b1111;
		put_beat(b);
		put_beat(make_beat(OP_RESET));
		put_beat(addr_beat(1'b1, 1'b1, 8'd1));
		put_beat(data_beat(1'b1, 1'b0, 8'h00));
		put_beat(data_beat(1'b1, 1'b0, 8'h00));  // all sent: complete

		// --- random phases, one enable setting each ---
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			set_config(phase_cfg[ph]);
			calm = (ph == 2);
			// overfill the receive buffer once so the full case is hit
			if (ph == 0)
				run_frame(1'b0, RECV_DEPTH + 2, 8'd0);
			target = beats_sent + ITEMS / PHASES;
			while (beats_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					run_frame(1'b0, ($urandom_range(0, 99) < 15) ? $urandom_range(28, 35)
						: $urandom_range(0, 6), 8'($urandom));
				else if (r < 75)
					run_frame(1'b1, $urandom_range(0, 8), ($urandom_range(0, 99) < 10)
						? 8'($urandom_range(33, 255)) : 8'($urandom_range(0, 6)));
				else if (r < 83)
					repeat ($urandom_range(1, 4)) put_beat(make_beat(OP_LOAD));
				else if (r < 97)
					put_beat(make_beat(op_kind_t'($urandom_range(0, 5))));
				else
					drain();
			end
		end
		calm = 1'b0;

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- i2c_slave_buffer_controller_unit.f -----
rtl/core/i2csbc_pkg.sv
rtl/core/i2csbc_front.sv
rtl/core/i2csbc_queue.sv
rtl/core/i2csbc_back.sv
rtl/core/i2c_slave_buffer_controller_unit.sv
bench/i2csbc_tb_pkg.sv
bench/i2csbc_checker.sv
bench/tb_top.sv
